// ----- sv/lbd_pkg.sv -----
// Shared types, constants and the constant-divide helper for the lattice bond decode block.
package lbd_pkg;

  localparam int LATTICE_X_DEF = 8;
  localparam int LATTICE_Y_DEF = 8;
  localparam int OP_KINDS_DEF  = 2;

  localparam int SITE_W      = 7;
  localparam int ENTRY_W     = 9;
  localparam int CALC_W      = 16;
  localparam int RECIP_SHIFT = 16;

  // boundary_mode codes
  localparam logic BC_PERIODIC    = 1'b0;
  localparam logic BC_CYLINDRICAL = 1'b1;

  // operator kind that flips both end spins
  localparam int KIND_OFFDIAG = 1;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_PROPAGATE = 2'd1,
    OP_READ      = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SITE_W-1:0]   site;
    logic                spin_in;
    logic [ENTRY_W-1:0]  op_entry;
  } lbd_item_t;

  typedef struct packed {
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
    logic              flipped;
    logic              strong_bond;
    logic              spin_read;
    logic              bad_bond;
  } lbd_result_t;

  typedef struct packed {
    logic [CALC_W-1:0] quo;
    logic [CALC_W-1:0] rem;
  } divmod_t;

  // Quotient and remainder by a constant divisor: multiply by the truncated
  // reciprocal, then one correction step. Exact for value * divisor < 2^RECIP_SHIFT.
  function automatic divmod_t divmod_const(input logic [CALC_W-1:0] value,
                                           input logic [CALC_W-1:0] divisor,
                                           input logic [CALC_W-1:0] recip);
    logic [2*CALC_W-1:0] prod;
    logic [CALC_W-1:0]   q;
    logic [CALC_W-1:0]   r;
    divmod_t             res;
    prod = (2*CALC_W)'(value) * (2*CALC_W)'(recip);
    q    = prod[RECIP_SHIFT +: CALC_W];
    r    = value - CALC_W'(q * divisor);
    if (r >= divisor) begin
      q = q + CALC_W'(1);
      r = r - divisor;
    end
    res.quo = q;
    res.rem = r;
    return res;
  endfunction

endpackage

// ----- sv/lbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lbd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lbd_bond_decode.sv -----
// Bond index to end-site decode for periodic and cylindrical square lattices.
module lbd_bond_decode
  import lbd_pkg::*;
#(
  parameter int LATTICE_X = LATTICE_X_DEF,
  parameter int LATTICE_Y = LATTICE_Y_DEF
) (
  input  logic [ENTRY_W-1:0]                              bond,
  input  logic                                            mode,
  output logic [$clog2((LATTICE_X+1)*LATTICE_Y)-1:0]      site_a,
  output logic [$clog2((LATTICE_X+1)*LATTICE_Y)-1:0]      site_b,
  output logic                                            j_bond
);

  localparam int ADDR_W = $clog2((LATTICE_X + 1) * LATTICE_Y);

  localparam logic [CALC_W-1:0] LX       = CALC_W'(LATTICE_X);
  localparam logic [CALC_W-1:0] LX_LAST  = CALC_W'(LATTICE_X - 1);
  localparam logic [CALC_W-1:0] STRIDE_C = CALC_W'(LATTICE_X + 1);
  localparam logic [CALC_W-1:0] H_CNT    = CALC_W'(LATTICE_X * LATTICE_Y);
  localparam logic [CALC_W-1:0] LAST_P   = CALC_W'((LATTICE_Y - 1) * LATTICE_X);
  localparam logic [CALC_W-1:0] LAST_C   = CALC_W'((LATTICE_Y - 1) * (LATTICE_X + 1));
  localparam logic [CALC_W-1:0] RECIP_LX = CALC_W'((1 << RECIP_SHIFT) / LATTICE_X);

  logic [CALC_W-1:0] b;
  logic [CALC_W-1:0] bb;
  logic [CALC_W-1:0] x;
  logic [CALC_W-1:0] y;
  logic [CALC_W-1:0] a;
  logic [CALC_W-1:0] c;
  divmod_t           dm;

  always_comb begin
    b      = CALC_W'(bond);
    bb     = b - H_CNT;
    dm     = divmod_const(b, LX, RECIP_LX);
    x      = dm.rem;
    y      = dm.quo;
    j_bond = 1'b0;
    if (b < H_CNT) begin
      // horizontal: site index is b itself in the periodic layout, b + y with the extra column
      if (mode == BC_CYLINDRICAL) begin
        a      = b + y;
        c      = b + y + CALC_W'(1);
        j_bond = ~x[0];
      end else begin
        a      = b;
        c      = (x == LX_LAST) ? b + CALC_W'(1) - LX : b + CALC_W'(1);
        j_bond = ~x[0] && (x != LX_LAST);
      end
    end else begin
      // vertical: bb is the lower site; top row wraps to row zero
      a = bb;
      if (mode == BC_CYLINDRICAL) begin
        c = (bb >= LAST_C) ? bb - LAST_C : bb + STRIDE_C;
      end else begin
        c = (bb >= LAST_P) ? bb - LAST_P : bb + LX;
      end
    end
    site_a = ADDR_W'(a);
    site_b = ADDR_W'(c);
  end

endmodule

// ----- sv/lattice_bond_decode_spin_flip_unit.sv -----
// Spin lattice store with bond decode and two-site spin flip: top level.
//
// Items enter on start/item and are taken at a clock edge where start is high
// and busy is low. Each item gives one result beat on result, marked by a
// one-cycle result_stb; the receiver cannot stall, so every beat must be
// captured in the cycle it is shown.
// A beat is registered from the item register into the result register; a propagate
// item that flips spins first steps through its RAM phases in the item register.
// Throughput: load, read, diagonal and out-of-range propagate items go at one
// per cycle. A flipping propagate item holds busy in its first and second phases: both end
// spins are read and rewritten through the one read port and one write port of
// the spin RAM, so such an item steps through PH_FIRST, PH_SECOND and PH_LAST.
// The boundary mode register is written with cfg_we/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce; reset sets it to periodic.
// Reset clears the pipeline and the result strobe. Spin contents are not
// cleared: every site must be loaded before it is read or flipped.
module lattice_bond_decode_spin_flip_unit
  import lbd_pkg::*;
#(
  parameter int LATTICE_X = LATTICE_X_DEF,
  parameter int LATTICE_Y = LATTICE_Y_DEF,
  parameter int OP_KINDS  = OP_KINDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  lbd_item_t   item,
  output logic        result_stb,
  output lbd_result_t result,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int DEPTH  = (LATTICE_X + 1) * LATTICE_Y;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [CALC_W-1:0] KINDS       = CALC_W'(OP_KINDS);
  localparam logic [CALC_W-1:0] RECIP_KINDS = CALC_W'((1 << RECIP_SHIFT) / OP_KINDS);
  localparam logic [CALC_W-1:0] COUNT_PER   = CALC_W'(2 * LATTICE_X * LATTICE_Y);
  localparam logic [CALC_W-1:0] COUNT_CYL   =
      CALC_W'(LATTICE_X * LATTICE_Y + (LATTICE_X + 1) * LATTICE_Y);
  localparam logic [CALC_W-1:0] DEPTH_C     = CALC_W'(DEPTH);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LAST
  } phase_t;

  // control
  logic        boundary_mode;
  logic        s1_valid;
  phase_t      ph;
  logic        accept;
  logic        s1_done;

  // entry split at the input
  divmod_t           dm_entry;
  logic [CALC_W-1:0] bond_count;
  logic              acc_bad;
  logic              acc_flip;

  // item register
  opcode_t            s1_opcode;
  logic [SITE_W-1:0]  s1_site;
  logic               s1_spin;
  logic [ENTRY_W-1:0] s1_bond;
  logic               s1_bad;
  logic               s1_flip;
  logic               s1_site_ok;
  logic [ADDR_W-1:0]  s1_addr;

  logic [ADDR_W-1:0]  dec_a;
  logic [ADDR_W-1:0]  dec_b;
  logic               dec_j_bond;

  // spin RAM
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic               rd_data;

  // result register
  lbd_result_t res;
  lbd_result_t res_next;
  logic        res_rd;
  logic        res_rd_next;

  always_comb begin
    dm_entry   = divmod_const(CALC_W'(item.op_entry), KINDS, RECIP_KINDS);
    bond_count = (boundary_mode == BC_CYLINDRICAL) ? COUNT_CYL : COUNT_PER;
    acc_bad    = (item.opcode == OP_PROPAGATE) && (dm_entry.quo >= bond_count);
    acc_flip   = (item.opcode == OP_PROPAGATE) && !acc_bad &&
                 (dm_entry.rem == CALC_W'(KIND_OFFDIAG));
  end

  assign busy    = s1_valid && s1_flip && (ph != PH_LAST);
  assign accept  = start && !busy;
  assign s1_done = s1_valid && !busy;

  assign s1_site_ok = CALC_W'(s1_site) < DEPTH_C;
  assign s1_addr    = ADDR_W'(s1_site);

  lbd_bond_decode #(
    .LATTICE_X (LATTICE_X),
    .LATTICE_Y (LATTICE_Y)
  ) u_decode (
    .bond   (s1_bond),
    .mode   (boundary_mode),
    .site_a (dec_a),
    .site_b (dec_b),
    .j_bond (dec_j_bond)
  );

  // RAM port steering: a flip reads a, then writes ~a while reading b, then writes ~b
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dec_a;
    ram_wdata = ~rd_data;
    ram_raddr = dec_a;
    if (s1_valid) begin
      case (ph)
        PH_FIRST: begin
          if (s1_opcode == OP_READ) begin
            ram_raddr = s1_addr;
          end
          if (s1_opcode == OP_LOAD && s1_site_ok) begin
            ram_we    = 1'b1;
            ram_waddr = s1_addr;
            ram_wdata = s1_spin;
          end
        end
        PH_SECOND: begin
          ram_we    = 1'b1;
          ram_waddr = dec_a;
          ram_raddr = dec_b;
        end
        PH_LAST: begin
          ram_we    = 1'b1;
          ram_waddr = dec_b;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  lbd_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    res_next    = '0;
    res_rd_next = 1'b0;
    case (s1_opcode)
      OP_PROPAGATE: begin
        if (s1_bad) begin
          res_next.bad_bond = 1'b1;
        end else begin
          res_next.site_a      = SITE_W'(dec_a);
          res_next.site_b      = SITE_W'(dec_b);
          res_next.strong_bond = dec_j_bond;
          res_next.flipped     = s1_flip;
        end
      end
      OP_READ: begin
        res_rd_next = s1_site_ok;
      end
      default: begin
        res_rd_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_mode <= BC_PERIODIC;
      s1_valid      <= 1'b0;
      ph            <= PH_FIRST;
      result_stb    <= 1'b0;
    end else begin
      if (cfg_we) begin
        boundary_mode <= cfg_wdata;
      end
      if (accept) begin
        s1_valid  <= 1'b1;
        ph        <= PH_FIRST;
        s1_opcode <= item.opcode;
        s1_site   <= item.site;
        s1_spin   <= item.spin_in;
        s1_bond   <= dm_entry.quo[ENTRY_W-1:0];
        s1_bad    <= acc_bad;
        s1_flip   <= acc_flip;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (busy) begin
        ph <= (ph == PH_FIRST) ? PH_SECOND : PH_LAST;
      end
      result_stb <= s1_done;
      if (s1_done) begin
        res    <= res_next;
        res_rd <= res_rd_next;
      end
    end
  end

  // read data comes straight from the RAM output register in the beat cycle
  always_comb begin
    result           = res;
    result.spin_read = res_rd & rd_data;
  end

  a_plain_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && !acc_flip) |-> ##2 result_stb)
    else $error("non-flip item did not give its beat two cycles after accept");

  a_flip_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && acc_flip) |-> ##4 (result_stb && result.flipped))
    else $error("flip item did not give a flipped beat four cycles after accept");

  a_flip_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && acc_flip) |=> busy ##1 busy ##1 !busy)
    else $error("busy window of a flip item is not two cycles");

  a_bad_no_flip: assert property (@(posedge clk) disable iff (rst)
    result_stb |-> !(result.bad_bond && result.flipped))
    else $error("out-of-range bond reported a flip");

endmodule
